@@ design/rab_pkg.sv @@
// shared types and constants for the rational accumulator
`default_nettype none

package rab_pkg;

  // default internal word width and the fixed width of each numeric field
  localparam int WORD_BITS_DEF = 32;
  localparam int FIELD_BITS    = 32;

  typedef enum logic [2:0] {
    OP_LOAD = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } rab_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_REDUCE,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_OUT
  } rab_state_t;

  typedef enum logic [1:0] {
    GP_IDLE,
    GP_TWOS,
    GP_ODD,
    GP_LOOP
  } rab_gcd_ph_t;

endpackage

`default_nettype wire

@@ design/rab_mul.sv @@
// shift-add multiplier, product kept modulo 2^W
`default_nettype none

module rab_mul import rab_pkg::*; #(
  parameter int W = WORD_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] mul_a,
  input  wire logic [W-1:0] mul_b,
  output logic              done,
  output logic [W-1:0]      prod
);

  logic         busy_r;
  logic         done_r;
  logic [W-1:0] mc_r;
  logic [W-1:0] mp_r;
  logic [W-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (mp_r == '0)) begin
        // stop as soon as no set multiplier bits remain
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc_r  <= mul_a;
      mp_r  <= mul_b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + (mp_r[0] ? mc_r : '0);
      mc_r  <= mc_r << 1;
      mp_r  <= mp_r >> 1;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

`default_nettype wire

@@ design/rab_gcd.sv @@
// binary gcd of two nonzero magnitudes, one step per cycle
`default_nettype none

module rab_gcd import rab_pkg::*; #(
  parameter int W = WORD_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] gcd_a,
  input  wire logic [W-1:0] gcd_b,
  output logic              done,
  output logic [W-1:0]      gcd
);

  localparam int SW = $clog2(W);

  rab_gcd_ph_t   ph_r;
  rab_gcd_ph_t   ph_nxt;
  logic [W-1:0]  a_r;
  logic [W-1:0]  b_r;
  logic [SW-1:0] sh_r;
  logic          a_gt_b;

  assign a_gt_b = (a_r > b_r);

  always_comb begin
    ph_nxt = ph_r;
    unique case (ph_r)
      GP_IDLE: if (start) ph_nxt = GP_TWOS;
      GP_TWOS: if (a_r[0] || b_r[0]) ph_nxt = GP_ODD;
      GP_ODD:  if (a_r[0]) ph_nxt = GP_LOOP;
      GP_LOOP: if (b_r == '0) ph_nxt = GP_IDLE;
      default: ph_nxt = GP_IDLE;
    endcase
  end

  always_comb begin
    done = (ph_r == GP_LOOP) && (b_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= GP_IDLE;
    end else begin
      ph_r <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && (ph_r == GP_IDLE)) begin
      a_r  <= gcd_a;
      b_r  <= gcd_b;
      sh_r <= '0;
    end else begin
      case (ph_r)
        GP_TWOS: begin
          // strip common factors of two
          if (!(a_r[0] || b_r[0])) begin
            a_r  <= a_r >> 1;
            b_r  <= b_r >> 1;
            sh_r <= sh_r + SW'(1);
          end
        end
        GP_ODD: begin
          if (!a_r[0]) a_r <= a_r >> 1;
        end
        GP_LOOP: begin
          if (b_r != '0) begin
            if (!b_r[0]) begin
              b_r <= b_r >> 1;
            end else if (a_gt_b) begin
              a_r <= b_r;
              b_r <= a_r - b_r;
            end else begin
              b_r <= b_r - a_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign gcd = a_r << sh_r;

endmodule

`default_nettype wire

@@ design/rab_div.sv @@
// restoring divider, one quotient bit per cycle
`default_nettype none

module rab_div import rab_pkg::*; #(
  parameter int W = WORD_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quot
);

  localparam int CW = $clog2(W);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  dvs_r;
  logic [W:0]    sh;
  logic [W+1:0]  df;
  logic          fits;

  assign sh   = {rem_r, quo_r[W-1]};
  assign df   = {1'b0, sh} - {2'b00, dvs_r};
  assign fits = !df[W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? df[W-1:0] : sh[W-1:0];
      quo_r <= {quo_r[W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

`default_nettype wire

@@ design/rational_accumulator_binary_gcd.sv @@
// top level: rational accumulator with binary gcd reduction
//
//  channel  dir  ports                          beat carries
//  in       in   in_tvalid/in_tready/tdata/tuser op, operand numerator and denominator
//  out      out  out_tvalid/out_tready/tdata/tuser reduced numerator, denominator, status
//
// steps: load and unused ops go straight to the output; others run the shift-add
//   multiplier two or three times, then, unless the result has a zero numerator or
//   denominator, the binary gcd and the divider twice
// reset: held value clears to 0/1, no item in flight, out_tvalid low
// stalls: in_tready is high only between items; one finished beat may wait in
//   the output register while the next item is already being worked
`default_nettype none

module rational_accumulator_binary_gcd import rab_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] operand_num, [63:32] operand_den
  input  wire logic [2:0]  in_tuser,   // [2:0] op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [31:0] result_num, [63:32] result_den
  output logic [0:0]       out_tuser   // [0] status
);

  localparam int W = WORD_BITS;

  rab_state_t state_r;
  rab_state_t state_nxt;
  logic       launch_r;

  rab_op_t    in_op;
  rab_op_t    op_r;

  // operand fields brought to word width
  logic [W-1:0] in_num_w;
  logic [W-1:0] in_den_w;

  logic [W-1:0] opn_r;
  logic [W-1:0] opd_r;
  logic [W-1:0] held_num_r;
  logic [W-1:0] held_num_nxt;
  logic [W-1:0] held_den_r;
  logic [W-1:0] held_den_nxt;
  logic [W-1:0] p1_r;
  logic [W-1:0] p2_r;
  logic [W-1:0] an_r;
  logic [W-1:0] ad_r;
  logic         neg_n_r;
  logic         neg_d_r;
  logic [W-1:0] g_r;
  logic [W-1:0] qn_r;
  logic [W-1:0] num_new;

  logic [FIELD_BITS-1:0] res_num;
  logic [FIELD_BITS-1:0] res_den;

  logic         out_tvalid_r;
  logic [63:0]  out_tdata_r;
  logic [0:0]   out_tuser_r;
  logic         out_load;

  // shared unit hookups
  logic         mul_start;
  logic [W-1:0] mul_a;
  logic [W-1:0] mul_b;
  logic         mul_done;
  logic [W-1:0] mul_prod;
  logic         gcd_start;
  logic         gcd_done;
  logic [W-1:0] gcd_val;
  logic         div_start;
  logic [W-1:0] div_x;
  logic         div_done;
  logic [W-1:0] div_quot;

  assign in_op = rab_op_t'(in_tuser);

  // sign-extend the 32-bit fields into the word, or keep the low bits
  if (W > FIELD_BITS) begin : g_wide_in
    assign in_num_w = {{(W - FIELD_BITS){in_tdata[31]}}, in_tdata[31:0]};
    assign in_den_w = {{(W - FIELD_BITS){in_tdata[63]}}, in_tdata[63:32]};
  end else begin : g_narrow_in
    assign in_num_w = in_tdata[W-1:0];
    assign in_den_w = in_tdata[32 +: W];
  end

  // results carry the low 32 bits of the held word, zero-filled when narrower
  if (W >= FIELD_BITS) begin : g_wide_out
    assign res_num = held_num_r[FIELD_BITS-1:0];
    assign res_den = held_den_r[FIELD_BITS-1:0];
  end else begin : g_narrow_out
    assign res_num = {{(FIELD_BITS - W){1'b0}}, held_num_r};
    assign res_den = {{(FIELD_BITS - W){1'b0}}, held_den_r};
  end

  // numerator combine after the products are in
  always_comb begin
    case (op_r)
      OP_ADD:  num_new = p1_r + p2_r;
      OP_SUB:  num_new = p1_r - p2_r;
      default: num_new = p1_r;
    endcase
  end

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          unique case (in_op) inside
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: state_nxt = ST_MUL1;
            default:                        state_nxt = ST_OUT;
          endcase
        end
      end
      ST_MUL1: begin
        if (mul_done) begin
          state_nxt = ((op_r == OP_ADD) || (op_r == OP_SUB)) ? ST_MUL2 : ST_MUL3;
        end
      end
      ST_MUL2: if (mul_done) state_nxt = ST_MUL3;
      ST_MUL3: if (mul_done) state_nxt = ST_REDUCE;
      ST_REDUCE: begin
        // zero denominator stays as is, zero numerator becomes 0/1
        if ((held_den_r == '0) || (held_num_r == '0)) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_GCD;
        end
      end
      ST_GCD:  if (gcd_done) state_nxt = ST_DIVN;
      ST_DIVN: if (div_done) state_nxt = ST_DIVD;
      ST_DIVD: if (div_done) state_nxt = ST_OUT;
      ST_OUT:  if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer: outputs and unit operand steering
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    out_load  = (state_r == ST_OUT) && (!out_tvalid_r || out_tready);
    mul_start = 1'b0;
    gcd_start = 1'b0;
    div_start = 1'b0;
    mul_a     = held_den_r;
    mul_b     = opd_r;
    div_x     = an_r;
    unique case (state_r)
      ST_MUL1: begin
        mul_start = launch_r;
        mul_a     = held_num_r;
        mul_b     = (op_r == OP_MUL) ? opn_r : opd_r;
      end
      ST_MUL2: begin
        mul_start = launch_r;
        mul_a     = opn_r;
        mul_b     = held_den_r;
      end
      ST_MUL3: begin
        mul_start = launch_r;
        mul_a     = held_den_r;
        mul_b     = (op_r == OP_DIV) ? opn_r : opd_r;
      end
      ST_GCD:  gcd_start = launch_r;
      ST_DIVN: div_start = launch_r;
      ST_DIVD: begin
        div_start = launch_r;
        div_x     = ad_r;
      end
      default: ;
    endcase
  end

  // held fraction update
  always_comb begin
    held_num_nxt = held_num_r;
    held_den_nxt = held_den_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && (in_op == OP_LOAD)) begin
          held_num_nxt = in_num_w;
          held_den_nxt = in_den_w;
        end
      end
      ST_MUL3: begin
        if (mul_done) begin
          held_num_nxt = num_new;
          held_den_nxt = mul_prod;
        end
      end
      ST_REDUCE: begin
        if ((held_den_r != '0) && (held_num_r == '0)) held_den_nxt = W'(1);
      end
      ST_DIVD: begin
        if (div_done) begin
          // signs are kept, magnitudes replaced by the reduced quotients
          held_num_nxt = neg_n_r ? (W'(0) - qn_r) : qn_r;
          held_den_nxt = neg_d_r ? (W'(0) - div_quot) : div_quot;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      launch_r     <= 1'b0;
      held_num_r   <= '0;
      held_den_r   <= W'(1);
      out_tvalid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      // one-cycle kick for the unit of the state just entered
      launch_r   <= (state_nxt != state_r);
      held_num_r <= held_num_nxt;
      held_den_r <= held_den_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && in_tvalid) begin
      op_r  <= in_op;
      opn_r <= in_num_w;
      opd_r <= in_den_w;
    end
    if ((state_r == ST_MUL1) && mul_done) p1_r <= mul_prod;
    if ((state_r == ST_MUL2) && mul_done) p2_r <= mul_prod;
    if (state_r == ST_REDUCE) begin
      // most negative word gives 2^(W-1) as an unsigned magnitude
      neg_n_r <= held_num_r[W-1];
      neg_d_r <= held_den_r[W-1];
      an_r    <= held_num_r[W-1] ? (W'(0) - held_num_r) : held_num_r;
      ad_r    <= held_den_r[W-1] ? (W'(0) - held_den_r) : held_den_r;
    end
    if ((state_r == ST_GCD) && gcd_done)  g_r  <= gcd_val;
    if ((state_r == ST_DIVN) && div_done) qn_r <= div_quot;
    if (out_load) begin
      out_tdata_r <= {res_den, res_num};
      out_tuser_r <= (held_den_r == '0);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  rab_mul #(.W(W)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  rab_gcd #(.W(W)) u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_start),
    .gcd_a (an_r),
    .gcd_b (ad_r),
    .done  (gcd_done),
    .gcd   (gcd_val)
  );

  rab_div #(.W(W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_x),
    .divisor  (g_r),
    .done     (div_done),
    .quot     (div_quot)
  );

endmodule

`default_nettype wire

@@ test/rational_accumulator_binary_gcd_tb.sv @@
// testbench for the rational accumulator: stream stimulus, fraction predictor, result scoreboard
`timescale 1ns / 100ps

module rational_accumulator_binary_gcd_tb;
  import rab_pkg::*;

  // op codes the block leaves unused, the held value must pass through untouched
  localparam logic [2:0]  OP_SPARE_LO  = 3'd5;
  localparam logic [2:0]  OP_SPARE_MID = 3'd6;
  localparam logic [2:0]  OP_SPARE_HI  = 3'd7;
  localparam logic [31:0] WORD_MIN    = 32'h8000_0000;
  localparam logic [31:0] WORD_MAX    = 32'h7fff_ffff;
  localparam logic [31:0] WORD_ONES   = 32'hffff_ffff;
  localparam int          HOLD_CYCLES = 2500;  // long receiver hold-off
  localparam int          DRAIN_WAIT  = 300;   // idle tail after the last owed result is back

  // one expected result beat
  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    logic        zero_den;
  } frac_result_t;

  // tracks the held fraction and the results still owed by the block
  class frac_scoreboard;
    logic [31:0]  acc_num;
    logic [31:0]  acc_den;
    frac_result_t owed_q[$];
    int           errors;

    function new();
      acc_num = '0;
      acc_den = 32'd1;
      errors  = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function logic [31:0] abs_word(logic [31:0] x);
      return x[31] ? 32'd0 - x : x;
    endfunction

    // stein gcd of two nonzero magnitudes
    function logic [31:0] stein_gcd(logic [31:0] a, logic [31:0] b);
      logic [31:0] t;
      int          k;
      k = 0;
      while (!a[0] && !b[0]) begin
        a = a >> 1;
        b = b >> 1;
        k++;
      end
      while (!a[0]) a = a >> 1;
      while (b != 0) begin
        while (!b[0]) b = b >> 1;
        if (a > b) begin
          t = a;
          a = b;
          b = t;
        end
        b = b - a;
      end
      return a << k;
    endfunction

    // divide both words by the gcd of the magnitudes, signs stay where they are
    function void reduce_acc();
      logic [31:0] g;
      logic [31:0] qn;
      logic [31:0] qd;
      if (acc_den == 0) return;
      if (acc_num == 0) begin
        acc_den = 32'd1;
        return;
      end
      g  = stein_gcd(abs_word(acc_num), abs_word(acc_den));
      qn = abs_word(acc_num) / g;
      qd = abs_word(acc_den) / g;
      acc_num = acc_num[31] ? 32'd0 - qn : qn;
      acc_den = acc_den[31] ? 32'd0 - qd : qd;
    endfunction

    // accepted operand beat: update the held fraction, queue the result it causes
    function void note_operand(logic [2:0] op, logic [31:0] n, logic [31:0] d);
      logic [31:0]  a;
      logic [31:0]  b;
      frac_result_t r;
      a = acc_num;
      b = acc_den;
      case (op)
        OP_LOAD: begin
          acc_num = n;
          acc_den = d;
        end
        OP_ADD: begin
          acc_num = a * d + n * b;
          acc_den = b * d;
          reduce_acc();
        end
        OP_SUB: begin
          acc_num = a * d - n * b;
          acc_den = b * d;
          reduce_acc();
        end
        OP_MUL: begin
          acc_num = a * n;
          acc_den = b * d;
          reduce_acc();
        end
        OP_DIV: begin
          acc_num = a * d;
          acc_den = b * n;
          reduce_acc();
        end
        default: ;
      endcase
      r.num      = acc_num;
      r.den      = acc_den;
      r.zero_den = (acc_den == 0);
      owed_q.push_back(r);
    endfunction

    // accepted result beat: compare each field with the oldest owed result
    function void check_result(logic [63:0] data, logic status);
      frac_result_t e;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: result with none owed, num %h den %h status %b",
                 $time, data[31:0], data[63:32], status);
        return;
      end
      e = owed_q.pop_front();
      if (data[31:0] !== e.num) begin
        errors++;
        $display("%0t: numerator expected %h actual %h", $time, e.num, data[31:0]);
      end
      if (data[63:32] !== e.den) begin
        errors++;
        $display("%0t: denominator expected %h actual %h", $time, e.den, data[63:32]);
      end
      if (status !== e.zero_den) begin
        errors++;
        $display("%0t: status expected %b actual %b", $time, e.zero_den, status);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;   // [31:0] operand_num, [63:32] operand_den
  logic [2:0]  in_tuser   = '0;   // [2:0] op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;         // [31:0] result_num, [63:32] result_den
  logic [0:0]  out_tuser;         // [0] status

  frac_scoreboard sb;
  bit in_gaps_on    = 1'b1;  // sender idles in bursts
  bit out_gaps_on   = 1'b1;  // receiver stalls in bursts
  bit hold_out_req  = 1'b0;  // ask the receiver for one long hold-off

  rational_accumulator_binary_gcd dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // offer one operand beat, optionally after an idle burst, and hold it until taken;
  // tvalid stays high after acceptance so back-to-back beats need no second write
  task automatic send_item(input logic [2:0] op, input logic [31:0] n, input logic [31:0] d);
    if (in_gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {d, n};
    do @(posedge clk); while (!in_tready);
    sb.note_operand(op, n, d);
  endtask

  // operand mix: mostly small values with shared factors, plus full words,
  // powers of two and the word extremes
  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: w = 32'($signed($urandom_range(0, 40)) - 20);
      5, 6:          w = $urandom;
      7:             w = 32'd1 << $urandom_range(0, 31);
      8: begin
        case ($urandom_range(0, 4))
          0:       w = WORD_MIN;
          1:       w = WORD_MAX;
          2:       w = '0;
          3:       w = 32'd1;
          default: w = WORD_ONES;
        endcase
      end
      default:       w = 32'($urandom_range(1, 1000) * $urandom_range(1, 64));
    endcase
    if ($urandom_range(0, 3) == 0) w = 32'd0 - w;
    return w;
  endfunction

  task automatic send_random();
    logic [2:0]  op;
    logic [31:0] n;
    logic [31:0] d;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 8)       op = OP_LOAD;
    else if (pick < 96) op = 3'($urandom_range(OP_ADD, OP_DIV));
    else                op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    n = pick_word();
    d = pick_word();
    // a zero denominator sticks until the next load, so keep it rare
    if (d == 0 && $urandom_range(0, 3) != 0) d = 32'd1;
    if (op == OP_LOAD && d == 0 && $urandom_range(0, 1) == 0) d = 32'd7;
    send_item(op, n, d);
  endtask

  // every result beat is checked at the edge it is taken
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser[0]);
  end

  // receiver: random stall bursts, one long hold-off on request, none at the end
  initial begin
    int hold_left;
    forever begin
      @(posedge clk);
      if (hold_out_req) begin
        hold_out_req = 1'b0;
        out_tready <= 1'b0;
        hold_left = HOLD_CYCLES;
        while (hold_left > 0) begin
          @(posedge clk);
          hold_left--;
        end
      end else if (out_gaps_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: spare op straight out of reset reports 0/1
    send_item(OP_SPARE_LO, 32'd123, 32'd456);
    // load keeps 6/8 unreduced, then each arithmetic op with a reduction
    send_item(OP_LOAD, 32'd6, 32'd8);
    send_item(OP_ADD, 32'd1, 32'd6);
    send_item(OP_SUB, 32'd5, 32'd12);
    send_item(OP_MUL, 32'hffff_fffc, 32'd9);
    send_item(OP_DIV, 32'd2, 32'hffff_fffd);        // negative operand denominator lands in the numerator
    // zero numerator: load leaves 0/5, an op collapses it to 0/1
    send_item(OP_LOAD, 32'd0, 32'd5);
    send_item(OP_ADD, 32'd0, 32'd7);
    // zero denominator: flagged on load and carried through unreduced
    send_item(OP_LOAD, 32'd7, 32'd0);
    send_item(OP_MUL, 32'd3, 32'd2);
    send_item(OP_SPARE_HI, WORD_ONES, WORD_ONES);
    // most negative word: magnitude taken as unsigned
    send_item(OP_LOAD, WORD_MIN, 32'd1);
    send_item(OP_MUL, 32'd1, 32'd1);
    send_item(OP_LOAD, WORD_MIN, WORD_MIN);
    send_item(OP_MUL, 32'd1, 32'd1);
    send_item(OP_LOAD, WORD_MAX, WORD_MAX);
    send_item(OP_ADD, WORD_MAX, WORD_MIN);          // products wrap
    send_item(OP_DIV, 32'd0, 32'd1);                // zero operand numerator divides to x/0
    send_item(OP_LOAD, 32'd1, 32'd1);
    send_item(OP_DIV, WORD_MIN, WORD_MAX);
    send_item(OP_MUL, WORD_MAX, WORD_MIN);
    send_item(OP_SUB, WORD_MIN, WORD_MIN);
    send_item(OP_LOAD, WORD_ONES, WORD_ONES);
    send_item(OP_SPARE_MID, 32'h5a5a_a5a5, 32'ha5a5_5a5a);
    send_item(OP_ADD, 32'd1, WORD_ONES);

    // random part: idling on both sides, one long receiver hold-off while the
    // sender keeps offering, one sender pause until everything has come back
    for (int i = 0; i < 1400; i++) begin
      if (i == 300) hold_out_req = 1'b1;
      if (i == 700) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      if (i == 1200) begin
        in_gaps_on  = 1'b0;
        out_gaps_on = 1'b0;
      end
      send_random();
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[rational_accumulator_binary_gcd] OK");
    end else begin
      $display("[rational_accumulator_binary_gcd] ERROR");
    end
    $finish;
  end

  // watchdog, far above the slowest correct run
  initial begin
    #25_000_000;
    $display("[rational_accumulator_binary_gcd] ERROR");
    $finish;
  end

endmodule
